FILE: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath interface types of the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Default pool shape: 2^LEVELS minimum blocks of 2^MIN_BLOCK_LOG bytes.
   localparam int LEVELS_DEF        = 10;
   localparam int MIN_BLOCK_LOG_DEF = 6;

   // Internal order width, enough for any order a request can ask for.
   localparam int ORDER_W = 5;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOMEM    = 2'd1;
   localparam logic [1:0] ST_NOTALLOC = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;     // latch a new request
      logic       clr_step;    // one step of the clearing pass
      logic       scan_start;  // start the search at the requested order
      logic       scan_next;   // next node of the same level
      logic       level_next;  // first node of the next larger order
      logic       claim;       // mark the found node as taken
      logic       split;       // free the upper half, descend to the lower
      logic       alloc_rec;   // record the allocation
      logic       free_rec;    // drop the record, load the freed leaf node
      logic       buddy_clr;   // take the free buddy, move to the parent
      logic       node_set;    // mark the current node free
      logic       resp_load;   // load the result register
      logic [1:0] resp_code;   // status for the result register
   } bba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;     // current request is a free
      logic too_big;     // requested order exceeds the pool
      logic bad_offset;  // free offset misaligned or beyond the pool
      logic node_bit;    // node free bit read in the previous cycle
      logic leaf_valid;  // allocation record valid bit read last cycle
      logic scan_last;   // current node is the last of its level
      logic ord_top;     // current order is the whole pool
      logic ord_gt_k;    // current order still above the requested one
      logic node_root;   // current node is the root
      logic clr_last;    // clearing pass at its last entry
   } bba_stat_type;

endpackage

FILE: rtl/core/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Request registers, tree walk registers, the node free and allocation
// record memories, and the result register of the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int LEVELS        = bba_pkg::LEVELS_DEF,
   parameter int MIN_BLOCK_LOG = bba_pkg::MIN_BLOCK_LOG_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_action,
   input  logic [16:0]          req_request_bytes,
   input  logic [15:0]          req_free_offset,
   input  bba_pkg::bba_cmd_type cmd,
   output bba_pkg::bba_stat_type stat,
   output logic [15:0]          rsp_block_offset,
   output logic [3:0]           rsp_block_order,
   output logic [1:0]           rsp_status
);

   localparam int NODE_W     = LEVELS + 1;
   localparam int NODE_DEPTH = 2 ** NODE_W;
   localparam int LEAF_DEPTH = 2 ** LEVELS;
   localparam int OW         = bba_pkg::ORDER_W;
   localparam logic [17:0]   MINSZ_M1 = 18'((1 << MIN_BLOCK_LOG) - 1);
   localparam logic [31:0]   LOWMASK  = 32'((1 << MIN_BLOCK_LOG) - 1);
   localparam logic [OW-1:0] LEV      = OW'(LEVELS);

   logic              action_ff;
   logic [15:0]       offset_ff;
   logic [OW-1:0]     k_ff, k_in;
   logic              too_big_ff;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] clr_ff;
   logic [15:0]       rsp_offset_ff;
   logic [3:0]        rsp_order_ff;
   logic [1:0]        rsp_status_ff;

   // Order of a new allocate request: bit length of (blocks - 1).
   logic [17:0]   blocks;
   logic [17:0]   blocks_m1;
   logic [OW-1:0] req_k;
   always_comb begin
      blocks    = ({1'b0, req_request_bytes} + MINSZ_M1) >> MIN_BLOCK_LOG;
      blocks_m1 = (blocks == 18'd0) ? 18'd0 : blocks - 18'd1;
      req_k     = '0;
      for (int j = 0; j < 18; j++) begin
         if (blocks_m1[j]) begin
            req_k = OW'(j + 1);
         end
      end
   end

   // Leaf index of a free request.
   logic [31:0]       off_wide;
   logic [31:0]       idx_wide;
   logic [LEVELS-1:0] free_idx;
   assign off_wide = {16'd0, offset_ff};
   assign idx_wide = off_wide >> MIN_BLOCK_LOG;
   assign free_idx = idx_wide[LEVELS-1:0];

   // Leaf index and byte offset of the allocated node.
   logic [31:0]       node_sh;
   logic [LEVELS-1:0] alloc_idx;
   logic [31:0]       alloc_off;
   assign node_sh   = {{(32 - NODE_W){1'b0}}, node_ff} << k_ff;
   assign alloc_idx = node_sh[LEVELS-1:0];
   assign alloc_off = {{(32 - LEVELS){1'b0}}, alloc_idx} << MIN_BLOCK_LOG;

   // Level bounds of the scan.
   logic [OW-1:0]     depth;
   logic [NODE_W-1:0] first_up, first_k;
   logic [NODE_W:0]   last_p1;
   assign depth     = LEV - ord_ff;
   assign first_k   = NODE_W'(1) << (LEV - k_ff);
   assign first_up  = NODE_W'(1) << (depth - OW'(1));
   assign last_p1   = (NODE_W + 1)'(2) << depth;

   // Memory ports.
   logic              node_we, node_wd, node_rd;
   logic [NODE_W-1:0] node_wa, node_ra;
   logic              leaf_we, leaf_wd, leaf_rd;
   logic [LEVELS-1:0] leaf_wa;
   logic [OW-1:0]     order_rd;

   // Node free memory write selection.
   always_comb begin
      node_we = 1'b0;
      node_wa = node_ff;
      node_wd = 1'b0;
      if (cmd.clr_step) begin
         node_we = 1'b1;
         node_wa = clr_ff;
         node_wd = (clr_ff == NODE_W'(1));
      end else if (cmd.claim) begin
         node_we = 1'b1;
      end else if (cmd.split) begin
         node_we = 1'b1;
         node_wa = {node_ff[NODE_W-2:0], 1'b1};
         node_wd = 1'b1;
      end else if (cmd.buddy_clr) begin
         node_we = 1'b1;
         node_wa = node_ff ^ NODE_W'(1);
      end else if (cmd.node_set) begin
         node_we = 1'b1;
         node_wd = 1'b1;
      end
   end
   assign node_ra = action_ff ? (node_ff ^ NODE_W'(1)) : node_ff;

   // Allocation record write selection.
   always_comb begin
      leaf_we = 1'b0;
      leaf_wa = free_idx;
      leaf_wd = 1'b0;
      if (cmd.clr_step) begin
         leaf_we = ~clr_ff[NODE_W-1];
         leaf_wa = clr_ff[LEVELS-1:0];
      end else if (cmd.alloc_rec) begin
         leaf_we = 1'b1;
         leaf_wa = alloc_idx;
         leaf_wd = 1'b1;
      end else if (cmd.free_rec) begin
         leaf_we = 1'b1;
      end
   end

   bba_ram #(.WIDTH(1), .DEPTH(NODE_DEPTH)) u_node_free (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_addr (node_ra),
      .rd_data (node_rd)
   );

   bba_ram #(.WIDTH(1), .DEPTH(LEAF_DEPTH)) u_alloc_valid (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_wa),
      .wr_data (leaf_wd),
      .rd_addr (free_idx),
      .rd_data (leaf_rd)
   );

   bba_ram #(.WIDTH(OW), .DEPTH(LEAF_DEPTH)) u_alloc_order (
      .clock   (clock),
      .wr_en   (cmd.alloc_rec),
      .wr_addr (alloc_idx),
      .wr_data (k_ff),
      .rd_addr (free_idx),
      .rd_data (order_rd)
   );

   // Walk register updates.
   logic [OW-1:0] free_k;
   assign free_k = (order_rd > LEV) ? LEV : order_rd;
   always_comb begin
      k_in    = k_ff;
      ord_in  = ord_ff;
      node_in = node_ff;
      if (cmd.capture) begin
         k_in = req_k;
      end else if (cmd.scan_start) begin
         ord_in  = k_ff;
         node_in = first_k;
      end else if (cmd.scan_next) begin
         node_in = node_ff + NODE_W'(1);
      end else if (cmd.level_next) begin
         ord_in  = ord_ff + OW'(1);
         node_in = first_up;
      end else if (cmd.split) begin
         ord_in  = ord_ff - OW'(1);
         node_in = {node_ff[NODE_W-2:0], 1'b0};
      end else if (cmd.free_rec) begin
         k_in    = free_k;
         node_in = {1'b1, free_idx} >> free_k;
      end else if (cmd.buddy_clr) begin
         node_in = node_ff >> 1;
      end
   end

   // Request and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         offset_ff  <= req_free_offset;
         too_big_ff <= (req_k > LEV);
      end
      k_ff    <= k_in;
      ord_ff  <= ord_in;
      node_ff <= node_in;
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + NODE_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_status_ff <= cmd.resp_code;
         if (cmd.resp_code == bba_pkg::ST_OK) begin
            rsp_offset_ff <= action_ff ? offset_ff : alloc_off[15:0];
            rsp_order_ff  <= k_ff[3:0];
         end else begin
            rsp_offset_ff <= '0;
            rsp_order_ff  <= '0;
         end
      end
   end

   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_block_order  = rsp_order_ff;
   assign rsp_status       = rsp_status_ff;

   // Status to the controller.
   always_comb begin
      stat.is_free    = action_ff;
      stat.too_big    = too_big_ff;
      stat.bad_offset = ((off_wide & LOWMASK) != 32'd0) ||
                        (idx_wide >= 32'(LEAF_DEPTH));
      stat.node_bit   = node_rd;
      stat.leaf_valid = leaf_rd;
      stat.scan_last  = ({1'b0, node_ff} + (NODE_W + 1)'(1)) == last_p1;
      stat.ord_top    = (ord_ff == LEV);
      stat.ord_gt_k   = (ord_ff > k_ff);
      stat.node_root  = (node_ff == NODE_W'(1));
      stat.clr_last   = (clr_ff == {NODE_W{1'b1}});
   end

endmodule

FILE: rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the buddy block allocator: clearing pass, search and split
// for allocate, record check and buddy merge for free, result handshake.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bba_pkg::bba_stat_type stat,
   output bba_pkg::bba_cmd_type  cmd
);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_DECODE = 12'b000000000100,
      S_A_RD   = 12'b000000001000,
      S_A_CK   = 12'b000000010000,
      S_A_SPL  = 12'b000000100000,
      S_F_RD   = 12'b000001000000,
      S_F_CK   = 12'b000010000000,
      S_M_TEST = 12'b000100000000,
      S_M_RD   = 12'b001000000000,
      S_M_CK   = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_free) begin
               if (stat.bad_offset) begin
                  code_in  = bba_pkg::ST_NOTALLOC;
                  state_in = S_RESP;
               end else begin
                  state_in = S_F_RD;
               end
            end else if (stat.too_big) begin
               code_in  = bba_pkg::ST_NOMEM;
               state_in = S_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_A_RD;
            end
         end
         S_A_RD: begin
            state_in = S_A_CK;
         end
         S_A_CK: begin
            if (stat.node_bit) begin
               cmd.claim = 1'b1;
               state_in  = S_A_SPL;
            end else if (!stat.scan_last) begin
               cmd.scan_next = 1'b1;
               state_in      = S_A_RD;
            end else if (!stat.ord_top) begin
               cmd.level_next = 1'b1;
               state_in       = S_A_RD;
            end else begin
               code_in  = bba_pkg::ST_NOMEM;
               state_in = S_RESP;
            end
         end
         S_A_SPL: begin
            if (stat.ord_gt_k) begin
               cmd.split = 1'b1;
            end else begin
               cmd.alloc_rec = 1'b1;
               code_in       = bba_pkg::ST_OK;
               state_in      = S_RESP;
            end
         end
         S_F_RD: begin
            state_in = S_F_CK;
         end
         S_F_CK: begin
            if (stat.leaf_valid) begin
               cmd.free_rec = 1'b1;
               state_in     = S_M_TEST;
            end else begin
               code_in  = bba_pkg::ST_NOTALLOC;
               state_in = S_RESP;
            end
         end
         S_M_TEST: begin
            if (stat.node_root) begin
               cmd.node_set = 1'b1;
               code_in      = bba_pkg::ST_OK;
               state_in     = S_RESP;
            end else begin
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            state_in = S_M_CK;
         end
         S_M_CK: begin
            if (stat.node_bit) begin
               cmd.buddy_clr = 1'b1;
               state_in      = S_M_TEST;
            end else begin
               cmd.node_set = 1'b1;
               code_in      = bba_pkg::ST_OK;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.resp_load = 1'b1;
               cmd.resp_code = code_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Result valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff <= code_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a fixed pool of 2^LEVELS blocks of 2^MIN_BLOCK_LOG
// bytes, with allocate by size and free by offset.
// ----------------------------------------------------------------------------
// After reset a clearing pass runs through the node and record memories;
// requests are stalled meanwhile. One request is handled at a time, and
// each answers with one result. A successful allocate inspects tree nodes
// (the free bit memory is read one node at a time, smallest order first,
// lowest address first), then splits the found block down to the requested
// order; one that finds no fit, and one that is too large, answer with the
// no-memory status. A free checks the allocation record and then merges
// with its buddy while the buddy is free, at most LEVELS merges. A
// misaligned free offset and an unallocated one both answer with the
// not-allocated status. A result waits in an output register, so the next
// request is accepted while it is still unclaimed.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
   parameter int LEVELS        = bba_pkg::LEVELS_DEF,
   parameter int MIN_BLOCK_LOG = bba_pkg::MIN_BLOCK_LOG_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [16:0] req_request_bytes,
   input  logic [15:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_block_offset,
   output logic [3:0]  rsp_block_order,
   output logic [1:0]  rsp_status
);

   bba_pkg::bba_cmd_type  cmd;
   bba_pkg::bba_stat_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath #(
      .LEVELS        (LEVELS),
      .MIN_BLOCK_LOG (MIN_BLOCK_LOG)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_block_order   (rsp_block_order),
      .rsp_status        (rsp_status)
   );

   // A request just taken keeps the input stalled while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in progress");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bba_pkg::ST_OK ||
                     rsp_status == bba_pkg::ST_NOMEM ||
                     rsp_status == bba_pkg::ST_NOTALLOC))
      else $error("undefined status code");

   // A failed request reports a zero offset and order.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bba_pkg::ST_OK) |->
      (rsp_block_offset == 16'd0 && rsp_block_order == 4'd0))
      else $error("error result with nonzero fields");

endmodule
